@@ hw/rtl/crc32w_pkg.sv @@
// ----------------------------------------------------------------------------
// crc32w_pkg
// Shared types and constants for the word-wise CRC-32 engine.
// ----------------------------------------------------------------------------
package crc32w_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 3;

   localparam logic [WORD_W-1:0] CRC_POLY    = 32'h04C1_1DB7;
   localparam logic [WORD_W-1:0] CRC_SEED    = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] CRC_TOP_BIT = 32'h8000_0000;

   // byte counts with a meaning of their own
   localparam logic [COUNT_W-1:0] COUNT_NONE  = 3'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE   = 3'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO   = 3'd2;
   localparam logic [COUNT_W-1:0] COUNT_THREE = 3'd3;

   typedef struct packed {
      logic [WORD_W-1:0]  data_word;
      logic [COUNT_W-1:0] valid_bytes;
      logic               start_message;
   } req_payload_type;

   // input stage to CRC core
   typedef struct packed {
      logic            vld;
      logic            fire;
      req_payload_type payload;
   } stage_ctl_type;

   typedef logic [WORD_W-1:0] crc_cols_type [WORD_W];

   // 32 bit-steps of the MSB-first shift register, elaboration use only
   function automatic logic [WORD_W-1:0] adv_word(logic [WORD_W-1:0] r);
      logic [WORD_W-1:0] acc;
      acc = r;
      for (int k = 0; k < WORD_W; k++) begin
         if ((acc & CRC_TOP_BIT) != '0) begin
            acc = (acc << 1) ^ CRC_POLY;
         end else begin
            acc = acc << 1;
         end
      end
      return acc;
   endfunction

   // the advance is linear: column i is the image of bit i alone
   function automatic crc_cols_type adv_cols();
      crc_cols_type cols;
      for (int i = 0; i < WORD_W; i++) begin
         cols[i] = adv_word(WORD_W'(1) << i);
      end
      return cols;
   endfunction

   localparam crc_cols_type ADV_COLS = adv_cols();

endpackage

@@ hw/rtl/crc32w_req_if.sv @@
// ----------------------------------------------------------------------------
// crc32w_req_if
// Request channel: one message word with its byte count and start flag.
// ----------------------------------------------------------------------------
interface crc32w_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  valid_bytes;
   logic        start_message;

   modport source (output valid, output data_word, output valid_bytes,
                   output start_message, input ready);
   modport sink   (input valid, input data_word, input valid_bytes,
                   input start_message, output ready);
endinterface

@@ hw/rtl/crc32w_rsp_if.sv @@
// ----------------------------------------------------------------------------
// crc32w_rsp_if
// Response channel: running CRC after each word.
// ----------------------------------------------------------------------------
interface crc32w_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] crc_value;

   modport source (output valid, output crc_value, input ready);
   modport sink   (input valid, input crc_value, output ready);
endinterface

@@ hw/rtl/crc32_word_engine_top.sv @@
// ----------------------------------------------------------------------------
// crc32_word_engine_top
// Word-wise CRC-32, polynomial 04C11DB7, MSB first, no reflection, no final
// XOR.
//
// Usage: send message words on req_port. data_word carries bytes little-
// endian (first byte in bits 7..0); valid_bytes gives the kept low bytes
// (0 absorbs nothing, 5..7 act as 4); start_message reloads the CRC with
// all ones before the word. Every request transfer yields exactly one
// response on rsp_port carrying the running CRC after that word.
// The word sits in the input register, then the CRC lands in the result
// register. Throughput: one word per cycle while rsp_port does not stall;
// the whole 32-step advance is one XOR network between the two registers.
// Reset clears both stage valids and loads the CRC register with all ones.
// When rsp_port stalls, the result register holds, the input register still
// takes one more word, and req_port.ready then drops until the result
// transfers.
// ----------------------------------------------------------------------------
module crc32_word_engine_top
   import crc32w_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   crc32w_req_if.sink    req_port,
   crc32w_rsp_if.source  rsp_port
);

   stage_ctl_type     ctl;
   logic              out_free;
   logic [WORD_W-1:0] crc_next;

   crc32w_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .out_free (out_free),
      .ctl      (ctl)
   );

   crc32w_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .crc_next (crc_next)
   );

   crc32w_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (ctl.fire),
      .crc_next (crc_next),
      .out_free (out_free),
      .rsp_port (rsp_port)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready && ctl.vld |-> ctl.fire)
      else $error("request transfer would overwrite a held item");

   assert property (@(posedge clock) disable iff (reset)
      ctl.fire |-> !rsp_port.valid || rsp_port.ready)
      else $error("result register loaded while a result is stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_port.valid && !ctl.vld)
      else $error("stage valid set right after reset");

endmodule

@@ hw/rtl/crc32w_in_stage.sv @@
// ----------------------------------------------------------------------------
// crc32w_in_stage
// Input register: captures one request transfer, frees when the core fires.
// ----------------------------------------------------------------------------
module crc32w_in_stage
   import crc32w_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   crc32w_req_if.sink       req_port,
   input  logic             out_free,
   output stage_ctl_type    ctl
);

   logic            vld_ff;
   logic            vld_in;
   req_payload_type item_ff;
   logic            fire;
   logic            take;

   assign fire = vld_ff && out_free;
   assign take = req_port.valid && req_port.ready;
   assign req_port.ready = !vld_ff || fire;

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (fire) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_word     <= req_port.data_word;
         item_ff.valid_bytes   <= req_port.valid_bytes;
         item_ff.start_message <= req_port.start_message;
      end
   end

   assign ctl.vld     = vld_ff;
   assign ctl.fire    = fire;
   assign ctl.payload = item_ff;

endmodule

@@ hw/rtl/crc32w_core.sv @@
// ----------------------------------------------------------------------------
// crc32w_core
// CRC register with the combinational 32-bit XOR advance network.
// ----------------------------------------------------------------------------
module crc32w_core
   import crc32w_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  stage_ctl_type     ctl,
   output logic [WORD_W-1:0] crc_next
);

   logic [WORD_W-1:0] crc_ff;
   logic [WORD_W-1:0] crc_in;
   logic [WORD_W-1:0] base;
   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] mixed;
   logic [WORD_W-1:0] advanced;

   assign base = ctl.payload.start_message ? CRC_SEED : crc_ff;

   always_comb begin
      unique case (ctl.payload.valid_bytes)
         COUNT_NONE:  mask = '0;
         COUNT_ONE:   mask = 32'h0000_00FF;
         COUNT_TWO:   mask = 32'h0000_FFFF;
         COUNT_THREE: mask = 32'h00FF_FFFF;
         default:     mask = '1;
      endcase
   end

   assign mixed = base ^ (ctl.payload.data_word & mask);

   always_comb begin
      advanced = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (mixed[i]) begin
            advanced = advanced ^ ADV_COLS[i];
         end
      end
   end

   // empty word: reload only, no advance
   assign crc_next = (ctl.payload.valid_bytes == COUNT_NONE) ? base : advanced;
   assign crc_in   = ctl.fire ? crc_next : crc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_SEED;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ctl.fire && ctl.payload.start_message
         && (ctl.payload.valid_bytes == COUNT_NONE) |=> crc_ff == CRC_SEED)
      else $error("start with empty word did not reload the CRC register");

   assert property (@(posedge clock) disable iff (reset)
      ctl.fire |-> ctl.vld)
      else $error("core fired without a held item");

endmodule

@@ hw/rtl/crc32w_out_stage.sv @@
// ----------------------------------------------------------------------------
// crc32w_out_stage
// Result register: holds the running CRC until the response transfer.
// ----------------------------------------------------------------------------
module crc32w_out_stage
   import crc32w_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [WORD_W-1:0] crc_next,
   output logic              out_free,
   crc32w_rsp_if.source      rsp_port
);

   logic              vld_ff;
   logic              vld_in;
   logic [WORD_W-1:0] crc_value_ff;

   assign out_free = !vld_ff || rsp_port.ready;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_port.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         crc_value_ff <= crc_next;
      end
   end

   assign rsp_port.valid     = vld_ff;
   assign rsp_port.crc_value = crc_value_ff;

endmodule

@@ tb/sv/tb_crc32_word_engine_top.sv @@
// ----------------------------------------------------------------------------
// tb_crc32_word_engine_top
// Self-checking bench for the word-wise CRC-32 engine. Message words go in on
// the request channel: directed corner words first, then random messages with
// some broken framing and loose words mixed in. A scoreboard class keeps its
// own CRC register, predicts the running CRC of every request transfer and
// compares each response transfer against the oldest prediction. Both sides
// idle in random bursts, and the response side holds off once for a long
// stretch so the engine backs up onto its input.
// ----------------------------------------------------------------------------
module tb_crc32_word_engine_top
   import crc32w_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [COUNT_W-1:0] COUNT_FULL  = 3'd4;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 3'd7;
   localparam int unsigned        WORD_TARGET = 1300;
   localparam int unsigned        CALM_WORDS  = 200;
   localparam int unsigned        HOLD_AT     = 500;
   localparam int unsigned        HOLD_CYCLES = 100;

   // running CRC predictor and store of expected CRC values
   class crc_word_scoreboard;
      logic [WORD_W-1:0] crc_reg;
      logic [WORD_W-1:0] crc_expect_q[$];
      int unsigned       mismatch_count;

      function new();
         crc_reg        = CRC_SEED;
         mismatch_count = 0;
      endfunction

      // 32 MSB-first shift steps under the generator polynomial
      function logic [WORD_W-1:0] shift_word(logic [WORD_W-1:0] r);
         logic [WORD_W-1:0] acc;
         acc = r;
         for (int k = 0; k < WORD_W; k++) begin
            if (acc[WORD_W-1]) begin
               acc = (acc << 1) ^ CRC_POLY;
            end else begin
               acc = acc << 1;
            end
         end
         return acc;
      endfunction

      function void note_word(logic [WORD_W-1:0] data, logic [COUNT_W-1:0] count,
                              logic start);
         logic [WORD_W-1:0] keep_mask;
         case (count)
            COUNT_ONE:   keep_mask = 32'h0000_00FF;
            COUNT_TWO:   keep_mask = 32'h0000_FFFF;
            COUNT_THREE: keep_mask = 32'h00FF_FFFF;
            default:     keep_mask = 32'hFFFF_FFFF;
         endcase
         if (start) begin
            crc_reg = CRC_SEED;
         end
         // an empty word reports the register without advancing it
         if (count != COUNT_NONE) begin
            crc_reg = shift_word(crc_reg ^ (data & keep_mask));
         end
         crc_expect_q.push_back(crc_reg);
      endfunction

      function void check_crc(logic [WORD_W-1:0] actual);
         logic [WORD_W-1:0] expected;
         if (crc_expect_q.size() == 0) begin
            $error("crc_value: unexpected response, actual %h", actual);
            mismatch_count++;
            return;
         end
         expected = crc_expect_q.pop_front();
         if (actual !== expected) begin
            $error("crc_value mismatch: expected %h, actual %h", expected, actual);
            mismatch_count++;
         end
      endfunction

      function int unsigned pending();
         return crc_expect_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   crc32w_req_if req_bus ();
   crc32w_rsp_if rsp_bus ();

   crc32_word_engine_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   crc_word_scoreboard crc_sb = new();

   int unsigned words_sent  = 0;
   bit          idle_enable = 1'b1;
   bit          hold_request = 1'b0;
   bit          hold_done    = 1'b0;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #5ms;
      $display("crc32_word_engine_top verification failed");
      $finish;
   end

   // observe both channels at every edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            crc_sb.check_crc(rsp_bus.crc_value);
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            crc_sb.note_word(req_bus.data_word, req_bus.valid_bytes,
                             req_bus.start_message);
         end
      end
   end

   // response side: random stall bursts, one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic [WORD_W-1:0] data,
                            input logic [COUNT_W-1:0] count, input logic start);
      req_bus.valid         <= 1'b1;
      req_bus.data_word     <= data;
      req_bus.valid_bytes   <= count;
      req_bus.start_message <= start;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      words_sent++;
      if (words_sent == HOLD_AT) begin
         hold_request = 1'b1;
      end
      if (words_sent >= WORD_TARGET - CALM_WORDS) begin
         idle_enable = 1'b0;
      end
   endtask

   task automatic sender_gap();
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // well-formed message with occasional broken framing or odd counts
   task automatic send_random_message();
      int unsigned       len;
      logic [COUNT_W-1:0] cnt;
      logic              st;
      len = $urandom_range(1, 12);
      for (int unsigned k = 0; k < len; k++) begin
         st  = (k == 0);
         cnt = (k == len - 1) ? COUNT_W'($urandom_range(1, 4)) : COUNT_FULL;
         if ($urandom_range(0, 19) == 0) begin
            cnt = COUNT_W'($urandom_range(0, 7));
         end
         if ($urandom_range(0, 29) == 0) begin
            st = ~st;
         end
         sender_gap();
         send_word($urandom(), cnt, st);
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.data_word     <= '0;
      req_bus.valid_bytes   <= COUNT_NONE;
      req_bus.start_message <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first word without a start runs from the reset value
      send_word(32'h0000_0000, COUNT_FULL, 1'b0);
      send_word(32'hFFFF_FFFF, COUNT_FULL, 1'b0);
      send_word(32'h0000_0000, COUNT_FULL, 1'b1);
      send_word(32'hFFFF_FFFF, COUNT_FULL, 1'b1);
      send_word(32'h8000_0000, COUNT_FULL, 1'b1);
      send_word(32'h0000_0001, COUNT_FULL, 1'b0);
      // short final words
      send_word(32'hFFFF_FFFF, COUNT_ONE, 1'b1);
      send_word(32'hFFFF_FFFF, COUNT_TWO, 1'b0);
      send_word(32'hFFFF_FFFF, COUNT_THREE, 1'b0);
      send_word(32'h3433_3231, COUNT_FULL, 1'b1);
      send_word(32'h3837_3635, COUNT_FULL, 1'b0);
      send_word(32'hAAAA_AA39, COUNT_ONE, 1'b0);
      // empty words, with and without reload
      send_word(32'hDEAD_BEEF, COUNT_NONE, 1'b0);
      send_word(32'hDEAD_BEEF, COUNT_NONE, 1'b1);
      send_word(32'h1234_5678, COUNT_FULL, 1'b0);
      // counts above four act as full words
      send_word(32'hA5A5_A5A5, 3'd5, 1'b1);
      send_word(32'h5A5A_5A5A, 3'd6, 1'b0);
      send_word(32'hFFFF_FFFF, COUNT_MAX, 1'b0);
      send_word(32'h0000_0000, COUNT_MAX, 1'b1);
      send_word(32'h7FFF_FFFF, COUNT_THREE, 1'b0);

      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            sender_gap();
            send_word($urandom(), COUNT_W'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
         end else begin
            send_random_message();
         end
      end
      req_bus.valid <= 1'b0;

      while (crc_sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (crc_sb.mismatch_count == 0) begin
         $display("crc32_word_engine_top verification clean");
      end else begin
         $display("crc32_word_engine_top verification failed");
      end
      $finish;
   end

endmodule
